/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk with active-low rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/hsv2rgb_pkg.sv */
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Types and widths shared by the HSV to RGB pixel converter and its checker.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int CW     = 16;          // component and full-scale width
  localparam int WW     = CW + 2;      // holds 3 * component
  localparam int MMW    = 2 * CW;      // M * M
  localparam int BW     = 2 * CW + 2;  // base term, at most 3 * M * M
  localparam int NW     = 3 * CW + 2;  // dividend V * base
  localparam int QW     = CW + 2;      // quotient, at most 3 * M
  localparam int NFRONT = 7;           // stages ahead of the divider
  localparam int NDIV   = QW;          // one quotient bit per stage
  localparam int NSTG   = NFRONT + NDIV + 1;

  localparam logic [CW-1:0] MAX_RESET = CW'(255);

  typedef struct packed {
    logic [CW-1:0] hue;
    logic [CW-1:0] saturation;
    logic [CW-1:0] brightness;
  } hsv_pix_t;

  typedef struct packed {
    logic [CW-1:0] red;
    logic [CW-1:0] green;
    logic [CW-1:0] blue;
  } rgb_pix_t;

  typedef enum logic [1:0] {
    SEG_RG,
    SEG_GB,
    SEG_BR
  } seg_t;

endpackage

/* rtl/core/hsv_to_rgb_pixel.sv */
// Throughput: one pixel per clock while out_ready is high; every stage moves on
// its own, so bubbles close up and a stalled output holds only the full stages.
// The division by M*M is a restoring divider of 18 stages, one quotient bit each.
// Reset clears all stage valid bits and sets the full scale M back to 255.
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel
// Linear-hue HSV to RGB conversion with all components scaled to a
// programmable full scale M, results truncated and clipped to 0..M.
// ----------------------------------------------------------------------------
module hsv_to_rgb_pixel (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [15:0]           cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hsv2rgb_pkg::hsv_pix_t in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hsv2rgb_pkg::rgb_pix_t out_data
);
  import hsv2rgb_pkg::*;

  // Full scale and its square.
  logic [CW-1:0]  m_r;
  logic [CW-1:0]  m_nxt;
  logic [MMW-1:0] mm_r;

  // Stage valids and per-stage load enables.
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] en;

  // Stage 0..6 payload.
  hsv_pix_t       s0_r;
  logic [WW-1:0]  s1_h3_r;
  logic [CW-1:0]  s1_s_r, s1_v_r;
  logic [CW-1:0]  s1_h_c, s1_s_c, s1_v_c;
  seg_t           s2_seg_r, s2_seg_nxt;
  logic [CW-1:0]  s2_t_r, s2_t_nxt;
  logic [CW-1:0]  s2_s_r, s2_v_r;
  logic [WW-1:0]  s3_w_r [3];
  logic [WW-1:0]  s3_w_nxt [3];
  logic [CW-1:0]  s3_s_r, s3_v_r, s3_ms_r;
  logic [BW-1:0]  s4_sw_r [3];
  logic [MMW-1:0] s4_mms_r;
  logic [CW-1:0]  s4_v_r;
  logic [BW-1:0]  s5_base_r [3];
  logic [CW-1:0]  s5_v_r;
  logic [NW-1:0]  s6_num_r [3];

  // Divider pipeline.
  logic [NW-1:0]  dv_rem_r [NDIV-1][3];
  logic [QW-1:0]  dv_q_r   [NDIV][3];

  rgb_pix_t       out_r;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  assign m_nxt = (cfg_wdata == '0) ? CW'(1) : cfg_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r <= MAX_RESET;
    end else if (cfg_we) begin
      m_r <= m_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mm_r <= MMW'(m_r) * MMW'(m_r);
  end

  // --------------------------------------------------------------------------
  // Valid chain: a stage loads when it is empty or its content moves on.
  // --------------------------------------------------------------------------
  assign en[NSTG-1] = ~vld_r[NSTG-1] | out_ready;

  for (genvar gi = 0; gi < NSTG - 1; gi++) begin : g_en
    assign en[gi] = ~vld_r[gi] | en[gi+1];
  end

  assign vld_nxt = (en & {vld_r[NSTG-2:0], in_valid}) | (~en & vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NSTG-1];
  assign out_data  = out_r;

  // --------------------------------------------------------------------------
  // Stage 0: capture the request.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_r <= in_data;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: clamp to full scale, form 3 * hue.
  // --------------------------------------------------------------------------
  assign s1_h_c = (s0_r.hue        > m_r) ? m_r : s0_r.hue;
  assign s1_s_c = (s0_r.saturation > m_r) ? m_r : s0_r.saturation;
  assign s1_v_c = (s0_r.brightness > m_r) ? m_r : s0_r.brightness;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_h3_r <= (WW'(s1_h_c) << 1) + WW'(s1_h_c);
      s1_s_r  <= s1_s_c;
      s1_v_r  <= s1_v_c;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: pick the hue segment and the offset t within it (t <= M).
  // --------------------------------------------------------------------------
  always_comb begin
    if (s1_h3_r <= WW'(m_r)) begin
      s2_seg_nxt = SEG_RG;
      s2_t_nxt   = s1_h3_r[CW-1:0];
    end else if (s1_h3_r <= (WW'(m_r) << 1)) begin
      s2_seg_nxt = SEG_GB;
      s2_t_nxt   = CW'(s1_h3_r - WW'(m_r));
    end else begin
      s2_seg_nxt = SEG_BR;
      s2_t_nxt   = CW'(s1_h3_r - (WW'(m_r) << 1));
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_seg_r <= s2_seg_nxt;
      s2_t_r   <= s2_t_nxt;
      s2_s_r   <= s1_s_r;
      s2_v_r   <= s1_v_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: per-channel weight w = n + M, which is 3t for the rising color,
  // 3M - 3t for the falling one and zero for the off one. With it the base
  // term M*M + S*n becomes M*(M - S) + S*w, all unsigned.
  // --------------------------------------------------------------------------
  always_comb begin
    logic [WW-1:0] t3;
    logic [WW-1:0] tf;
    t3 = (WW'(s2_t_r) << 1) + WW'(s2_t_r);
    tf = (WW'(m_r) << 1) + WW'(m_r) - t3;
    case (s2_seg_r)
      SEG_RG: begin
        s3_w_nxt[0] = tf;
        s3_w_nxt[1] = t3;
        s3_w_nxt[2] = '0;
      end
      SEG_GB: begin
        s3_w_nxt[0] = '0;
        s3_w_nxt[1] = tf;
        s3_w_nxt[2] = t3;
      end
      SEG_BR: begin
        s3_w_nxt[0] = t3;
        s3_w_nxt[1] = '0;
        s3_w_nxt[2] = tf;
      end
      default: begin
        s3_w_nxt[0] = '0;
        s3_w_nxt[1] = '0;
        s3_w_nxt[2] = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_w_r  <= s3_w_nxt;
      s3_s_r  <= s2_s_r;
      s3_v_r  <= s2_v_r;
      s3_ms_r <= m_r - s2_s_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: products S*w per channel and M*(M - S).
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int c = 0; c < 3; c++) begin
        s4_sw_r[c] <= BW'(s3_s_r) * BW'(s3_w_r[c]);
      end
      s4_mms_r <= MMW'(m_r) * MMW'(s3_ms_r);
      s4_v_r   <= s3_v_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: base term, at most 3*M*M.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int c = 0; c < 3; c++) begin
        s5_base_r[c] <= s4_sw_r[c] + BW'(s4_mms_r);
      end
      s5_v_r <= s4_v_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: dividend V * base.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int c = 0; c < 3; c++) begin
        s6_num_r[c] <= NW'(s5_v_r) * NW'(s5_base_r[c]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Restoring divider by M*M, most significant quotient bit first. The
  // quotient is at most 3M, so QW bits cover it.
  // --------------------------------------------------------------------------
  for (genvar gj = 0; gj < NDIV; gj++) begin : g_div
    localparam int Sh = NDIV - 1 - gj;
    logic [NW-1:0] rem_prev [3];
    logic [QW-1:0] q_prev   [3];
    logic [NW-1:0] dsh;
    logic [2:0]    ge;

    if (gj == 0) begin : g_first
      assign rem_prev = s6_num_r;
      assign q_prev   = '{default: '0};
    end else begin : g_next
      assign rem_prev = dv_rem_r[gj-1];
      assign q_prev   = dv_q_r[gj-1];
    end

    assign dsh = NW'(mm_r) << Sh;

    for (genvar gc = 0; gc < 3; gc++) begin : g_ch
      assign ge[gc] = (rem_prev[gc] >= dsh);

      always_ff @(posedge clk) begin
        if (en[NFRONT+gj]) begin
          dv_q_r[gj][gc] <= {q_prev[gc][QW-2:0], ge[gc]};
        end
      end

      if (gj < NDIV - 1) begin : g_rem
        always_ff @(posedge clk) begin
          if (en[NFRONT+gj]) begin
            dv_rem_r[gj][gc] <= ge[gc] ? (rem_prev[gc] - dsh) : rem_prev[gc];
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: clip the quotient to M.
  // --------------------------------------------------------------------------
  function automatic logic [CW-1:0] clip_m(input logic [QW-1:0] q,
                                           input logic [CW-1:0] m);
    logic [CW-1:0] r;
    r = (q > QW'(m)) ? m : q[CW-1:0];
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en[NSTG-1]) begin
      out_r.red   <= clip_m(dv_q_r[NDIV-1][0], m_r);
      out_r.green <= clip_m(dv_q_r[NDIV-1][1], m_r);
      out_r.blue  <= clip_m(dv_q_r[NDIV-1][2], m_r);
    end
  end

endmodule

/* rtl/core/hsv2rgb_chk.sv */
// ----------------------------------------------------------------------------
// hsv2rgb_chk
// Port-level checks of the HSV to RGB converter, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hsv2rgb_chk (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  cfg_we,
  input logic [15:0]           cfg_wdata,
  input logic                  in_valid,
  input logic                  in_ready,
  input hsv2rgb_pkg::hsv_pix_t in_data,
  input logic                  out_valid,
  input logic                  out_ready,
  input hsv2rgb_pkg::rgb_pix_t out_data
);
  import hsv2rgb_pkg::*;

  // Full scale as seen on the configuration port.
  logic [CW-1:0] m_sh_r;
  logic          in_stall;
  logic          out_stall;
  logic          rgb_in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_sh_r <= MAX_RESET;
    end else if (cfg_we) begin
      m_sh_r <= (cfg_wdata == '0) ? CW'(1) : cfg_wdata;
    end
  end

  assign in_stall     = in_valid && !in_ready;
  assign out_stall    = out_valid && !out_ready;
  assign rgb_in_range = (out_data.red <= m_sh_r) && (out_data.green <= m_sh_r) &&
                        (out_data.blue <= m_sh_r);

  // A waiting request keeps its value until taken.
  `ASSERT_RST(a_in_hold, in_stall |=> in_valid && $stable(in_data), "waiting request changed")

  // A held result keeps its value until taken.
  `ASSERT_RST(a_out_hold, out_stall |=> out_valid && $stable(out_data), "held result changed")

  // Nothing comes out right after reset.
  `ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "out_valid after reset")

  // With the output stage empty the whole pipeline can move, so a request is taken.
  `ASSERT_RST(a_ready_free, !out_valid |-> in_ready, "in_ready low with empty output")

  // Every component stays within the full scale.
  `ASSERT_RST(a_out_range, out_valid |-> rgb_in_range, "component above full scale")

endmodule

bind hsv_to_rgb_pixel hsv2rgb_chk u_hsv2rgb_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .cfg_we    (cfg_we),
  .cfg_wdata (cfg_wdata),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* test/tb_hsv_to_rgb_pixel.sv */
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_pixel
// Drives HSV pixels through the converter under several full-scale settings
// and idle patterns, and checks every RGB pixel against an in-order model.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_pixel;
  timeunit 1ns;
  timeprecision 1ps;

  import hsv2rgb_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;
  localparam int NUM_PHASES = 6;
  localparam int PIXELS_PER_PHASE = 330;

  // Expected RGB pixels for accepted requests, oldest first.
  class hsv_rgb_tracker;
    logic [15:0] full_scale;
    rgb_pix_t    expected_rgb[$];
    int          errors;

    function new();
      full_scale = MAX_RESET;
      errors = 0;
    endfunction

    function void set_full_scale(logic [15:0] value);
      full_scale = value;
    endfunction

    function int pending();
      return expected_rgb.size();
    endfunction

    function logic [15:0] shade_level(longint m, longint s, longint v, longint n);
      longint mm;
      longint base;
      longint r;
      mm = m * m;
      base = mm + s * n;
      if (base < 0) begin
        return '0;
      end
      r = (v * base) / mm;
      if (r < 0) r = 0;
      if (r > m) r = m;
      return r[15:0];
    endfunction

    function rgb_pix_t convert_pixel(hsv_pix_t px);
      longint m, h, s, v, t, nr, ng, nb;
      rgb_pix_t rgb;
      m = (full_scale == 0) ? 1 : longint'(full_scale);
      h = (longint'(px.hue) > m) ? m : longint'(px.hue);
      s = (longint'(px.saturation) > m) ? m : longint'(px.saturation);
      v = (longint'(px.brightness) > m) ? m : longint'(px.brightness);
      if (3 * h <= m) begin
        t = 3 * h;
        ng = 3 * t - m;
        nr = 2 * m - 3 * t;
        nb = -m;
      end else if (3 * h <= 2 * m) begin
        t = 3 * h - m;
        nb = 3 * t - m;
        ng = 2 * m - 3 * t;
        nr = -m;
      end else begin
        t = 3 * h - 2 * m;
        nr = 3 * t - m;
        nb = 2 * m - 3 * t;
        ng = -m;
      end
      rgb.red = shade_level(m, s, v, nr);
      rgb.green = shade_level(m, s, v, ng);
      rgb.blue = shade_level(m, s, v, nb);
      return rgb;
    endfunction

    function void note_request(hsv_pix_t px);
      expected_rgb.push_back(convert_pixel(px));
    endfunction

    function void check_pixel(rgb_pix_t got);
      rgb_pix_t want;
      if (expected_rgb.size() == 0) begin
        $error("unexpected pixel red %0d green %0d blue %0d", got.red, got.green,
               got.blue);
        errors++;
        return;
      end
      want = expected_rgb.pop_front();
      if (got.red !== want.red) begin
        $error("red: expected %0d actual %0d", want.red, got.red);
        errors++;
      end
      if (got.green !== want.green) begin
        $error("green: expected %0d actual %0d", want.green, got.green);
        errors++;
      end
      if (got.blue !== want.blue) begin
        $error("blue: expected %0d actual %0d", want.blue, got.blue);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  hsv_pix_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  rgb_pix_t    out_data;

  hsv_rgb_tracker tracker = new();
  int send_idle = 0;
  int recv_idle = 0;
  int quiet_cycles = 0;

  hsv_to_rgb_pixel dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Receiver side: random back-pressure and result checking.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      tracker.check_pixel(out_data);
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[hsv_to_rgb_pixel] ERROR");
      $finish;
    end
  end

  task automatic send_pixel(input hsv_pix_t px);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    do begin
      @(posedge clk);
    end while (!in_ready);
    tracker.note_request(px);
  endtask

  task automatic drain_pixels();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  // Only called with the pipeline empty.
  task automatic write_full_scale(input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_full_scale(value);
  endtask

  // Favors zero, full scale, just above it, the segment boundaries and
  // fully random words so that every input bit toggles.
  function automatic logic [15:0] pick_level(int m, bit is_hue);
    int pick;
    int level;
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        level = 0;
      end
      1: begin
        level = m;
      end
      2: begin
        level = $urandom_range(0, 65535);
      end
      3: begin
        level = m + $urandom_range(1, 4);
      end
      4: begin
        if (is_hue) begin
          level = ($urandom_range(0, 1) ? m : 2 * m) / 3 + $urandom_range(0, 2) - 1;
        end else begin
          level = $urandom_range(0, m);
        end
      end
      default: begin
        level = $urandom_range(0, m);
      end
    endcase
    if (level < 0) level = 0;
    if (level > 65535) level = 65535;
    return 16'(level);
  endfunction

  initial begin
    logic [15:0] scale;
    int m;
    hsv_pix_t px;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase / 2)
        0: begin
          send_idle = 35;
          recv_idle = 54;
        end
        1: begin
          send_idle = 54;
          recv_idle = 35;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase

      case (phase)
        0: scale = 16'd255;
        1: scale = 16'hFFFF;
        2: scale = 16'd1;
        3: scale = 16'd0;
        4: scale = 16'($urandom_range(2, 65534));
        default: scale = 16'd6;
      endcase
      write_full_scale(scale);
      m = (scale == 0) ? 1 : int'(scale);

      if (phase == 0) begin
        // Segment boundaries, zero saturation and brightness, and inputs
        // above full scale.
        send_pixel({16'd0, 16'd255, 16'd255});
        send_pixel({16'd85, 16'd255, 16'd255});
        send_pixel({16'd86, 16'd255, 16'd255});
        send_pixel({16'd170, 16'd255, 16'd255});
        send_pixel({16'd171, 16'd255, 16'd255});
        send_pixel({16'd255, 16'd255, 16'd255});
        send_pixel({16'd43, 16'd255, 16'd255});
        send_pixel({16'd128, 16'd128, 16'd200});
        send_pixel({16'd213, 16'd100, 16'd255});
        send_pixel({16'd0, 16'd0, 16'd255});
        send_pixel({16'd100, 16'd0, 16'd0});
        send_pixel({16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_pixel({16'd256, 16'd300, 16'd1000});
        send_pixel({16'd0, 16'd255, 16'd0});
        send_pixel({16'd128, 16'd255, 16'd255});
        send_pixel({16'd1, 16'd1, 16'd1});
        send_pixel({16'd254, 16'd254, 16'd254});
        send_pixel({16'hAAAA, 16'h5555, 16'hAAAA});
        send_pixel({16'd42, 16'd200, 16'd17});
        send_pixel({16'd200, 16'd255, 16'd128});
      end

      for (int i = 0; i < PIXELS_PER_PHASE; i++) begin
        px.hue = pick_level(m, 1'b1);
        px.saturation = pick_level(m, 1'b0);
        px.brightness = pick_level(m, 1'b0);
        send_pixel(px);
      end
      drain_pixels();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("[hsv_to_rgb_pixel] OK");
    end else begin
      $display("[hsv_to_rgb_pixel] ERROR");
    end
    $finish;
  end

endmodule
